[rtl/core/mie_pkg.sv]
`default_nettype none
package mie_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_UP,
    ST_SCAN_DN,
    ST_SWAP,
    ST_REDUCE,
    ST_SIGN,
    ST_OUT
  } state_e;

  // Compare results of the shared shift-subtract unit.
  typedef struct packed {
    logic fit;   // shifted divisor fits under the partial remainder
    logic grow;  // twice the shifted divisor still fits
  } step_flags_t;

endpackage
`default_nettype wire

[rtl/core/mie_divstep.sv]
`default_nettype none
module mie_divstep #(
  parameter int unsigned WORD_BITS = mie_pkg::WORD_BITS_DEF
) (
  input  wire logic [WORD_BITS-1:0] rem_i,
  input  wire logic [WORD_BITS-1:0] dvs_i,
  input  wire logic [WORD_BITS-1:0] acc_i,
  input  wire logic [WORD_BITS-1:0] add_i,
  output mie_pkg::step_flags_t      flags_o,
  output logic      [WORD_BITS-1:0] rem_o,
  output logic      [WORD_BITS-1:0] acc_o
);

  always_comb begin
    flags_o.fit  = (dvs_i <= rem_i);
    flags_o.grow = ({dvs_i, 1'b0} <= {1'b0, rem_i});
    rem_o        = rem_i - dvs_i;
    // The coefficient sum never exceeds the modulus, so it fits the word.
    acc_o        = acc_i + add_i;
  end

endmodule
`default_nettype wire

[rtl/core/modular_inverse_ext_euclid.sv]
`default_nettype none
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   operand_i
// result    out        out_valid_o / out_stall_i inverse_o, divisor_o, exists_o
// config    in         modulus_we_i              modulus_i
//
// One word at a time. Each Euclid step runs in the shared shift-subtract unit: the
// divisor is shifted up, then subtracted back down bit by bit, then the pair is swapped.
// After the last step come reduction, sign fix and output. Modulus zero goes straight
// to output. Reset loads the modulus with 1000000007 and leaves the block idle. The
// result holds in its register while out_stall_i is high; no new word is taken until
// it has been delivered.
module modular_inverse_ext_euclid #(
  parameter int unsigned WORD_BITS = mie_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [WORD_BITS-1:0] operand_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [WORD_BITS-1:0] inverse_o,
  output logic      [WORD_BITS-1:0] divisor_o,
  output logic                      exists_o,
  input  wire logic                 modulus_we_i,
  input  wire logic [WORD_BITS-1:0] modulus_i
);

  localparam int unsigned CntW = $clog2(WORD_BITS);

  mie_pkg::state_e state_q, state_d;

  logic [WORD_BITS-1:0] modulus_q;
  logic [WORD_BITS-1:0] ra_q, rb_q, ma_q, mb_q;
  logic                 na_q;
  logic [WORD_BITS-1:0] rem_q, acc_q, dvs_q, add_q;
  logic [CntW-1:0]      cnt_q;
  logic [WORD_BITS-1:0] inverse_q, divisor_q;
  logic                 exists_q;

  mie_pkg::step_flags_t flags;
  logic [WORD_BITS-1:0] rem_sub, acc_sum;

  mie_divstep #(
    .WORD_BITS(WORD_BITS)
  ) u_divstep (
    .rem_i  (rem_q),
    .dvs_i  (dvs_q),
    .acc_i  (acc_q),
    .add_i  (add_q),
    .flags_o(flags),
    .rem_o  (rem_sub),
    .acc_o  (acc_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mie_pkg::MODULUS_RESET[WORD_BITS-1:0];
    end else if (modulus_we_i) begin
      modulus_q <= modulus_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mie_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mie_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (modulus_q == '0) ? mie_pkg::ST_OUT : mie_pkg::ST_SCAN_UP;
        end
      end
      mie_pkg::ST_SCAN_UP: begin
        if (!flags.grow) begin
          state_d = mie_pkg::ST_SCAN_DN;
        end
      end
      mie_pkg::ST_SCAN_DN: begin
        if (cnt_q == '0) begin
          state_d = mie_pkg::ST_SWAP;
        end
      end
      mie_pkg::ST_SWAP: begin
        state_d = (rem_q == '0) ? mie_pkg::ST_REDUCE : mie_pkg::ST_SCAN_UP;
      end
      mie_pkg::ST_REDUCE: state_d = mie_pkg::ST_SIGN;
      mie_pkg::ST_SIGN:   state_d = mie_pkg::ST_OUT;
      mie_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = mie_pkg::ST_IDLE;
        end
      end
      default: state_d = mie_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != mie_pkg::ST_IDLE);
    out_valid_o = (state_q == mie_pkg::ST_OUT);
  end

  // Datapath. A quotient is found by shifting the divisor up until it would
  // pass the remainder, then subtracting back down one bit per cycle while
  // the matching multiple of the old coefficient is added in.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mie_pkg::ST_IDLE: begin
        ra_q      <= operand_i;
        rb_q      <= modulus_q;
        ma_q      <= {{(WORD_BITS-1){1'b0}}, 1'b1};
        mb_q      <= '0;
        na_q      <= 1'b0;
        rem_q     <= operand_i;
        acc_q     <= {{(WORD_BITS-1){1'b0}}, 1'b1};
        dvs_q     <= modulus_q;
        add_q     <= '0;
        cnt_q     <= '0;
        inverse_q <= '0;
        divisor_q <= operand_i;
        exists_q  <= 1'b0;
      end
      mie_pkg::ST_SCAN_UP: begin
        if (flags.grow) begin
          dvs_q <= {dvs_q[WORD_BITS-2:0], 1'b0};
          add_q <= {add_q[WORD_BITS-2:0], 1'b0};
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      mie_pkg::ST_SCAN_DN: begin
        if (flags.fit) begin
          rem_q <= rem_sub;
          acc_q <= acc_sum;
        end
        if (cnt_q != '0) begin
          dvs_q <= {1'b0, dvs_q[WORD_BITS-1:1]};
          add_q <= {1'b0, add_q[WORD_BITS-1:1]};
          cnt_q <= cnt_q - CntW'(1);
        end
      end
      mie_pkg::ST_SWAP: begin
        ra_q  <= rb_q;
        rb_q  <= rem_q;
        ma_q  <= mb_q;
        mb_q  <= acc_q;
        na_q  <= !na_q;
        rem_q <= rb_q;
        acc_q <= mb_q;
        dvs_q <= rem_q;
        add_q <= acc_q;
        cnt_q <= '0;
      end
      mie_pkg::ST_REDUCE: begin
        // The final coefficient is at most the modulus, so one subtract reduces it.
        rem_q     <= (ma_q >= modulus_q) ? (ma_q - modulus_q) : ma_q;
        divisor_q <= ra_q;
      end
      mie_pkg::ST_SIGN: begin
        exists_q <= (ra_q == {{(WORD_BITS-1){1'b0}}, 1'b1});
        if (ra_q != {{(WORD_BITS-1){1'b0}}, 1'b1}) begin
          inverse_q <= '0;
        end else if (na_q && (rem_q != '0)) begin
          inverse_q <= modulus_q - rem_q;
        end else begin
          inverse_q <= rem_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign inverse_o = inverse_q;
  assign divisor_o = divisor_q;
  assign exists_o  = exists_q;

endmodule
`default_nettype wire
